>>> design/hsc_pkg.sv
`default_nettype none
package hsc_pkg;

    localparam int unsigned PREFIX_LEN = 13;
    localparam int unsigned LEN_SAT    = 14;
    localparam int unsigned VER_POS    = 7;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    typedef enum logic [1:0] {
        PH_HEADERS   = 2'd0,
        PH_BODY      = 2'd1,
        PH_CONFIRMED = 2'd2,
        PH_REJECTED  = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic       status_accepted;
        logic [3:0] line_length;
        logic       prefix_matches;
        logic       line_is_lone_cr;
        logic       previous_was_cr;
    } chk_state_t;

    localparam chk_state_t STATE_RESET = '{
        phase:           PH_HEADERS,
        status_accepted: 1'b0,
        line_length:     4'd0,
        prefix_matches:  1'b1,
        line_is_lone_cr: 1'b0,
        previous_was_cr: 1'b0
    };

    // lower-case status prefix, version digit handled separately
    function automatic logic [7:0] prefix_char(input logic [3:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                4'd0:    ch = 8'h68; // h
                4'd1:    ch = 8'h74; // t
                4'd2:    ch = 8'h74; // t
                4'd3:    ch = 8'h70; // p
                4'd4:    ch = 8'h2f; // /
                4'd5:    ch = 8'h31; // 1
                4'd6:    ch = 8'h2e; // .
                4'd7:    ch = 8'h30; // 0
                4'd8:    ch = 8'h20; // space
                4'd9:    ch = 8'h32; // 2
                4'd10:   ch = 8'h30; // 0
                4'd11:   ch = 8'h30; // 0
                4'd12:   ch = 8'h20; // space
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/http_status_header_checker.sv
// http status header checker
// s_ channel: one byte of an http response per transaction (s_data_byte),
// with s_restart high to clear all state before that byte is taken.
// m_ channel: one result per input byte: m_status (0 headers, 1 body after
// a good status line, 2 confirmed, 3 rejected) and m_status_changed.
// path: a byte accepted into the input register passes through the check
// logic, and its result is written into the result register.
// throughput: one byte per cycle while m_ready stays high, limited by the
// state update in the check logic between the two registers.
// stall: when m_ready is low the result register holds, the input register
// still takes one more byte, then s_ready drops until the result drains.
// reset: aresetn (synchronous, active low) empties both registers and puts
// the checker back in the header phase, as a restart would.
`default_nettype none
module http_status_header_checker
    import hsc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_restart,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic            m_status_changed
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_restart_reg;
    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic       changed_reg;
    chk_state_t state_reg;

    chk_state_t state_next;
    logic [1:0] status_next;
    logic       changed_next;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    hsc_step u_step (
        .cur_state      (state_reg),
        .data_byte      (in_data_reg),
        .restart        (in_restart_reg),
        .next_state     (state_next),
        .status         (status_next),
        .status_changed (changed_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg    <= s_data_byte;
            in_restart_reg <= s_restart;
        end
        if (advance) begin
            status_reg  <= status_next;
            changed_reg <= changed_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = status_reg;
    assign m_status_changed = changed_reg;

endmodule
`default_nettype wire

>>> design/hsc_step.sv
`default_nettype none
module hsc_step
    import hsc_pkg::*;
(
    input  wire chk_state_t cur_state,
    input  wire logic [7:0] data_byte,
    input  wire logic       restart,
    output chk_state_t      next_state,
    output logic [1:0]      status,
    output logic            status_changed
);

    chk_state_t s;
    logic [7:0] folded;
    logic       fits;
    logic       is_empty;

    always_comb begin
        s = restart ? STATE_RESET : cur_state;
        next_state = s;

        folded = data_byte;
        if (data_byte >= CH_UPA && data_byte <= CH_UPZ) begin
            folded = data_byte + CASE_OFS;
        end

        if (s.line_length >= 4'(PREFIX_LEN)) begin
            fits = 1'b1;
        end else if (s.line_length == 4'(VER_POS)) begin
            fits = (folded == CH_ZERO) || (folded == CH_ONE);
        end else begin
            fits = (folded == prefix_char(s.line_length));
        end

        is_empty = (s.line_length == 4'd0) ||
                   (s.line_length == 4'd1 && s.line_is_lone_cr);

        case (s.phase)
            PH_HEADERS: begin
                if (data_byte == CH_LF) begin
                    if (is_empty) begin
                        next_state.phase = s.status_accepted ? PH_BODY : PH_REJECTED;
                        next_state.previous_was_cr = 1'b0;
                    end else if (!s.status_accepted) begin
                        if (s.line_length >= 4'(PREFIX_LEN) && s.prefix_matches) begin
                            next_state.status_accepted = 1'b1;
                        end else begin
                            next_state.phase = PH_REJECTED;
                        end
                    end
                    next_state.line_length     = 4'd0;
                    next_state.prefix_matches  = 1'b1;
                    next_state.line_is_lone_cr = 1'b0;
                end else begin
                    if (!fits) begin
                        next_state.prefix_matches = 1'b0;
                    end
                    next_state.line_is_lone_cr = (s.line_length == 4'd0) &&
                                                 (data_byte == CH_CR);
                    if (s.line_length < 4'(LEN_SAT)) begin
                        next_state.line_length = s.line_length + 4'd1;
                    end
                end
            end
            PH_BODY: begin
                if (data_byte == CH_LF && s.previous_was_cr) begin
                    next_state.phase = PH_CONFIRMED;
                end
                next_state.previous_was_cr = (data_byte == CH_CR);
            end
            default: begin
                // confirmed and rejected hold until restart
            end
        endcase

        status         = next_state.phase;
        status_changed = (next_state.phase != s.phase);
    end

endmodule
`default_nettype wire

>>> bench/http_status_check_monitor.sv
`default_nettype none
module http_status_check_monitor
    import hsc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_restart,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [1:0] m_status,
    input  wire logic       m_status_changed,
    output int              mismatches,
    output int              waiting,
    output int              checked,
    output int              confirmed,
    output int              rejected
);

    // lower-case status prefix, the version digit is checked on its own
    localparam logic [8*13-1:0] STATUS_TEXT = "http/1.0 200 ";

    typedef struct packed {
        phase_t status;
        logic   changed;
    } status_note_t;

    chk_state_t   resp;
    status_note_t status_due[$];
    int           fail_count;
    int           results_seen;
    int           confirm_count;
    int           reject_count;

    task automatic track_byte(input logic [7:0] c, input logic restart);
        phase_t     was_phase;
        logic [7:0] low;
        logic       fits;
        logic       empty;
        if (restart) begin
            resp = STATE_RESET;
        end
        was_phase = resp.phase;
        low = (c >= CH_UPA && c <= CH_UPZ) ? c + CASE_OFS : c;
        if (resp.phase == PH_HEADERS) begin
            if (c == CH_LF) begin
                empty = (resp.line_length == 0) ||
                        (resp.line_length == 1 && resp.line_is_lone_cr);
                if (empty) begin
                    resp.phase = resp.status_accepted ? PH_BODY : PH_REJECTED;
                    resp.previous_was_cr = 1'b0;
                end else if (!resp.status_accepted) begin
                    if (resp.line_length >= PREFIX_LEN && resp.prefix_matches) begin
                        resp.status_accepted = 1'b1;
                    end else begin
                        resp.phase = PH_REJECTED;
                    end
                end
                resp.line_length = 4'd0;
                resp.prefix_matches = 1'b1;
                resp.line_is_lone_cr = 1'b0;
            end else begin
                if (resp.line_length >= PREFIX_LEN) begin
                    fits = 1'b1;
                end else if (resp.line_length == VER_POS) begin
                    fits = (low == CH_ZERO) || (low == CH_ONE);
                end else begin
                    fits = low == STATUS_TEXT[8*(PREFIX_LEN-1-resp.line_length) +: 8];
                end
                if (!fits) begin
                    resp.prefix_matches = 1'b0;
                end
                resp.line_is_lone_cr = (resp.line_length == 0) && (c == CH_CR);
                if (resp.line_length < LEN_SAT) begin
                    resp.line_length = resp.line_length + 4'd1;
                end
            end
        end else if (resp.phase == PH_BODY) begin
            if (c == CH_LF && resp.previous_was_cr) begin
                resp.phase = PH_CONFIRMED;
            end
            resp.previous_was_cr = c == CH_CR;
        end
        status_due.push_back('{resp.phase, resp.phase != was_phase});
    endtask

    always @(posedge aclk) begin
        status_note_t want;
        if (!aresetn) begin
            resp = STATE_RESET;
            status_due.delete();
            fail_count = 0;
            results_seen = 0;
            confirm_count = 0;
            reject_count = 0;
        end else begin
            // result side first: a byte accepted now cannot have its result yet
            if (m_valid && m_ready) begin
                results_seen++;
                if (status_due.size() == 0) begin
                    $error("m_status: expected no transaction, got %0d", m_status);
                    fail_count++;
                end else begin
                    want = status_due.pop_front();
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, got %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_status_changed !== want.changed) begin
                        $error("m_status_changed: expected %0d, got %0d",
                               want.changed, m_status_changed);
                        fail_count++;
                    end
                    if (want.changed && want.status == PH_CONFIRMED) begin
                        confirm_count++;
                    end
                    if (want.changed && want.status == PH_REJECTED) begin
                        reject_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                track_byte(s_data_byte, s_restart);
            end
        end
        mismatches <= fail_count;
        waiting <= status_due.size();
        checked <= results_seen;
        confirmed <= confirm_count;
        rejected <= reject_count;
    end

endmodule
`default_nettype wire

>>> bench/http_status_header_checker_test.sv
`default_nettype none
module http_status_header_checker_test;
    import hsc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_restart;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_status;
    logic       m_status_changed;

    int mismatches;
    int waiting;
    int checked;
    int confirmed;
    int rejected;

    logic       steady;
    int         holds_asked;
    int         holds_served = 0;
    int         hold_left = 0;
    int         cycle_count = 0;
    logic [7:0] wire_bytes[$];
    int         tail_len;
    int         useful;
    int         responses;

    http_status_header_checker i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_status_changed (m_status_changed)
    );

    http_status_check_monitor i_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_status_changed (m_status_changed),
        .mismatches       (mismatches),
        .waiting          (waiting),
        .checked          (checked),
        .confirmed        (confirmed),
        .rejected         (rejected)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("http_status_header_checker test failed");
            $finish;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holds_asked != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic restart);
        if (!steady) begin
            while ($urandom_range(99) < 31) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic put_text(input string s, input logic restart_first);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i], restart_first && i == 0);
        end
    endtask

    task automatic await_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (waiting != 0);
    endtask

    function automatic logic [7:0] header_text_byte();
        logic [7:0] v;
        int         r;
        r = $urandom_range(99);
        v = 8'($urandom_range(126, 32));
        if (r < 8) begin
            v = CH_CR;
        end else if (r < 14) begin
            v = 8'($urandom_range(255));
        end
        if (v == CH_LF) begin
            v = 8'h00;
        end
        return v;
    endfunction

    task automatic end_line();
        if ($urandom_range(9) < 7) begin
            wire_bytes.push_back(CH_CR);
        end
        wire_bytes.push_back(CH_LF);
    endtask

    // one response: mostly well-formed, some with a damaged or missing
    // status line, some plain noise
    task automatic make_response();
        int         kind;
        int         flaw;
        int         cut;
        int         pos;
        int         r;
        logic [7:0] c;
        string      head;
        head = "HTTP/1.0 200 ";
        wire_bytes.delete();
        tail_len = 0;
        kind = $urandom_range(99);
        if (kind >= 85) begin
            repeat ($urandom_range(12, 1)) begin
                wire_bytes.push_back($urandom_range(3) == 0 ? CH_LF : 8'($urandom_range(255)));
            end
            return;
        end
        // 1 damaged character, 2 cut short, 3 no status line
        flaw = (kind >= 65) ? $urandom_range(3, 1) : 0;
        if (flaw != 3) begin
            pos = $urandom_range(12);
            cut = (flaw == 2) ? $urandom_range(12, 1) : 13;
            for (int i = 0; i < cut; i++) begin
                c = head[i];
                if (i == VER_POS) begin
                    c = $urandom_range(1) ? CH_ONE : CH_ZERO;
                end else if (c >= CH_UPA && c <= CH_UPZ && $urandom_range(1)) begin
                    c = c + CASE_OFS;
                end
                if (flaw == 1 && i == pos) begin
                    case ($urandom_range(3))
                        0: c = 8'($urandom_range(255));
                        1: c ^= 8'h20;
                        2: c = c + 8'd1;
                        default: c |= 8'h80;
                    endcase
                end
                wire_bytes.push_back(c);
            end
            if ($urandom_range(1)) begin
                repeat ($urandom_range(5, 1)) wire_bytes.push_back(header_text_byte());
            end
            end_line();
        end
        repeat ($urandom_range(3)) begin
            repeat ($urandom_range(20, 1)) wire_bytes.push_back(header_text_byte());
            end_line();
        end
        end_line();
        repeat ($urandom_range(8)) begin
            r = $urandom_range(99);
            wire_bytes.push_back(r < 20 ? CH_CR : r < 35 ? CH_LF : 8'($urandom_range(255)));
        end
        if ($urandom_range(9) < 7) begin
            wire_bytes.push_back(CH_CR);
            wire_bytes.push_back(CH_LF);
        end
        tail_len = $urandom_range(2);
        repeat (tail_len) wire_bytes.push_back(8'($urandom_range(255)));
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(wire_bytes.size(), 1);
            while (wire_bytes.size() > cut) wire_bytes.pop_back();
            tail_len = 0;
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        s_restart = 1'b0;
        m_ready = 1'b0;
        steady = 1'b0;
        holds_asked = 0;
        useful = 0;
        responses = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // exact prefix line with mixed case, lone LF at body start,
        // then CR LF confirms and a final byte is ignored
        put_text("hTtP/1.0 200 \012\015\012\012\015\012", 1'b1);
        put_byte(8'hff, 1'b0);
        // NUL is an ordinary character, so this line is rejected
        put_byte(8'h00, 1'b1);
        put_byte(CH_LF, 1'b0);
        // empty line with no status line before it
        put_byte(CH_LF, 1'b1);

        while (useful < 1550) begin
            make_response();
            if (responses == 10) begin
                holds_asked <= holds_asked + 1;
            end
            if (responses == 25) begin
                await_idle();
            end
            if (responses == 40) begin
                steady <= 1'b1;
            end
            if (responses == 70) begin
                steady <= 1'b0;
            end
            for (int i = 0; i < wire_bytes.size(); i++) begin
                put_byte(wire_bytes[i],
                         (i == 0 && $urandom_range(9) != 0) || $urandom_range(199) == 0);
            end
            useful += wire_bytes.size() - tail_len;
            responses++;
        end

        await_idle();
        repeat (8) @(posedge aclk);
        $display("%0d responses, %0d bytes checked: %0d confirmed, %0d rejected",
                 responses, checked, confirmed, rejected);
        if (mismatches == 0 && waiting == 0) begin
            $display("http_status_header_checker test passed");
        end else begin
            $display("http_status_header_checker test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
